FILE: rtl/mfsp_pkg.sv
// Shared types, codes and helpers for the motor feedback and speed PID block.
// No dependencies; every other file imports this package.
package mfsp_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned MOTOR_COUNT_DEF    = 4;
  localparam int unsigned ENCODER_COUNTS_DEF = 8192;

  // The command frame always has four current slots.
  localparam int unsigned FRAME_SLOTS = 4;

  // Depth of the queue between the classifier and the execution pipeline.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Feedback frame ids start just above this base.
  localparam logic [10:0] FEEDBACK_BASE = 11'h200;

  // Input kind codes.
  localparam logic [1:0] KIND_FEEDBACK = 2'd0;
  localparam logic [1:0] KIND_SETPOINT = 2'd1;
  localparam logic [1:0] KIND_DISABLE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_MOTOR = 2'd1;
  localparam logic [1:0] STATUS_BAD_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAIN_P         = 3'd0;
  localparam logic [2:0] CFG_GAIN_I         = 3'd1;
  localparam logic [2:0] CFG_GAIN_D         = 3'd2;
  localparam logic [2:0] CFG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [2:0] CFG_OUTPUT_LIMIT   = 3'd4;

  // Configuration reset values.
  localparam logic signed [15:0] GAIN_P_RST         = 16'sd2048;
  localparam logic signed [15:0] GAIN_I_RST         = 16'sd26;
  localparam logic signed [15:0] GAIN_D_RST         = 16'sd0;
  localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd5000;
  localparam logic [14:0]        OUTPUT_LIMIT_RST   = 15'd16384;

  // What the execution pipeline does with a word.
  typedef enum logic [1:0] {
    OP_FEEDBACK,
    OP_SETPOINT,
    OP_DISABLE,
    OP_REJECT
  } op_e;

  // Classified word handed from the front end to the execution pipeline.
  typedef struct packed {
    op_e                op;
    logic [1:0]         status;
    logic [2:0]         motor;
    logic [15:0]        angle;
    logic signed [15:0] rpm;
    logic signed [15:0] current;
    logic [7:0]         temp;
    logic signed [15:0] target;
  } front_item_t;

  // Result fields other than the command frame.
  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         motor;
    logic [31:0]        ticks;
    logic signed [15:0] rpm;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } res_t;

  // Controller configuration.
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [15:0]        integral_limit;
    logic [14:0]        output_limit;
  } cfg_t;

  // Reduce a 16-bit angle modulo a constant of at least 256 by restoring
  // subtraction: the quotient has at most eight bits.
  function automatic logic [15:0] reduce_angle(logic [15:0] raw, int unsigned modulus);
    logic [23:0] rem;
    logic [23:0] step;
    int          k;
    rem = {8'd0, raw};
    for (k = 7; k >= 0; k--) begin
      step = 24'(modulus) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[15:0];
  endfunction

endpackage

FILE: rtl/mfsp_front.sv
// Front end: accepts input words, checks ids and unpacks the feedback payload.
// Depends on mfsp_pkg; feeds mfsp_queue.
module mfsp_front import mfsp_pkg::*; #(
  parameter int unsigned MOTOR_COUNT    = MOTOR_COUNT_DEF,
  parameter int unsigned ENCODER_COUNTS = ENCODER_COUNTS_DEF
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [10:0]        frame_id_i,
  input  logic [63:0]        payload_i,
  input  logic [2:0]         motor_id_i,
  input  logic signed [15:0] target_rpm_i,
  input  logic               q_full_i,
  output logic               push_o,
  output front_item_t        item_o
);

  localparam logic [10:0] LAST_FRAME = FEEDBACK_BASE + 11'(MOTOR_COUNT);
  localparam logic [2:0]  LAST_MOTOR = 3'(MOTOR_COUNT);

  logic known_kind;

  // A word is taken whenever the queue has room; unused kinds are dropped.
  assign in_ready_o = !q_full_i;
  assign known_kind = (kind_i == KIND_FEEDBACK) || (kind_i == KIND_SETPOINT) ||
                      (kind_i == KIND_DISABLE);
  assign push_o     = in_valid_i && !q_full_i && known_kind;

  // Classify the word and unpack the payload bytes.
  always_comb begin
    item_o         = '0;
    item_o.op      = OP_REJECT;
    item_o.status  = STATUS_OK;
    item_o.motor   = 3'd0;
    item_o.angle   = reduce_angle(payload_i[63:48], ENCODER_COUNTS);
    item_o.rpm     = payload_i[47:32];
    item_o.current = payload_i[31:16];
    item_o.temp    = payload_i[15:8];
    item_o.target  = target_rpm_i;
    unique case (kind_i) inside
      KIND_FEEDBACK: begin
        if (frame_id_i > FEEDBACK_BASE && frame_id_i <= LAST_FRAME) begin
          item_o.op    = OP_FEEDBACK;
          item_o.motor = 3'(frame_id_i - FEEDBACK_BASE);
        end else begin
          item_o.status = STATUS_BAD_FRAME;
        end
      end
      KIND_SETPOINT, KIND_DISABLE: begin
        if (motor_id_i != 3'd0 && motor_id_i <= LAST_MOTOR) begin
          item_o.op    = (kind_i == KIND_SETPOINT) ? OP_SETPOINT : OP_DISABLE;
          item_o.motor = motor_id_i;
        end else begin
          item_o.status = STATUS_BAD_MOTOR;
        end
      end
      default: begin
        item_o.op = OP_REJECT;
      end
    endcase
  end

endmodule

FILE: rtl/mfsp_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Depends on mfsp_pkg for the word type and depth.
module mfsp_queue import mfsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  front_item_t item_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        valid_o,
  output front_item_t item_o
);

  front_item_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]      count_q, count_d;
  logic                 do_pop;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push_i ? QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Word storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/mfsp_back.sv
// Execution pipeline: per-motor state, encoder unwrap, PID and frame packing.
// Depends on mfsp_pkg; takes words from mfsp_queue.
module mfsp_back import mfsp_pkg::*; #(
  parameter int unsigned MOTOR_COUNT    = MOTOR_COUNT_DEF,
  parameter int unsigned ENCODER_COUNTS = ENCODER_COUNTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  input  front_item_t        q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [2:0]         motor_o,
  output logic signed [31:0] total_ticks_o,
  output logic signed [15:0] speed_rpm_o,
  output logic signed [15:0] current_raw_o,
  output logic [7:0]         temperature_o,
  output logic               frame_valid_o,
  output logic [63:0]        command_payload_o
);

  localparam int unsigned MIDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int unsigned ANG_W  = $clog2(ENCODER_COUNTS);
  localparam logic signed [31:0] ENC_S  = 32'(ENCODER_COUNTS);
  localparam logic signed [31:0] HALF_S = 32'(ENCODER_COUNTS / 2);

  // Per-motor register file.
  logic [ANG_W-1:0]   prev_angle_q [MOTOR_COUNT];
  logic               seen_q       [MOTOR_COUNT];
  logic [31:0]        ticks_q      [MOTOR_COUNT];
  logic signed [15:0] rpm_q        [MOTOR_COUNT];
  logic signed [16:0] esum_q       [MOTOR_COUNT];
  logic signed [16:0] prev_err_q   [MOTOR_COUNT];
  logic signed [15:0] drive_q      [MOTOR_COUNT];

  // Pipeline registers.
  logic               s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  op_e                s1_op_q, s2_op_q, s3_op_q;
  res_t               s1_res_q, s2_res_q, s3_res_q, out_res_q;
  logic signed [16:0] s1_err_q, s1_esum_q;
  logic signed [17:0] s1_diff_q;
  logic signed [32:0] s2_p_q, s2_i_q;
  logic signed [33:0] s2_d_q;
  logic signed [35:0] s3_acc_q;
  logic               out_frame_valid_q;
  logic [63:0]        out_frame_q;

  // Stage A signals.
  logic               adv;
  logic               pop;
  logic [MIDX_W-1:0]  a_idx;
  logic [ANG_W-1:0]   a_ang;
  logic [ANG_W-1:0]   a_prev;
  logic signed [31:0] a_step_raw, a_step;
  logic [31:0]        a_ticks;
  logic signed [16:0] a_err;
  logic signed [17:0] a_sum, a_lim;
  logic signed [16:0] a_esum;
  logic signed [17:0] a_diff;
  res_t               a_res;

  // Final stage signals.
  logic [MIDX_W-1:0]  f_idx;
  logic               f_drive_wr;
  logic signed [35:0] f_acc_adj;
  logic signed [27:0] f_quo, f_lim;
  logic signed [15:0] f_drive;
  logic signed [15:0] drive_view [MOTOR_COUNT];
  logic [63:0]        f_frame;

  // The whole pipeline moves when the output register is free or drained.
  assign adv     = !out_valid_q || out_ready_i;
  assign pop     = adv && q_valid_i;
  assign q_pop_o = pop;

  // Stage A: encoder unwrap and error bookkeeping against the motor's state.
  always_comb begin
    a_idx  = MIDX_W'(q_item_i.motor - 3'd1);
    a_ang  = q_item_i.angle[ANG_W-1:0];
    a_prev = seen_q[a_idx] ? prev_angle_q[a_idx] : a_ang;
    a_step_raw = $signed(32'(a_ang)) - $signed(32'(a_prev));
    if (a_step_raw > HALF_S) begin
      a_step = a_step_raw - ENC_S;
    end else if (a_step_raw < -HALF_S) begin
      a_step = a_step_raw + ENC_S;
    end else begin
      a_step = a_step_raw;
    end
    a_ticks = ticks_q[a_idx] + 32'(a_step);

    a_err = 17'(q_item_i.target) - 17'(rpm_q[a_idx]);
    a_sum = 18'(esum_q[a_idx]) + 18'(a_err);
    a_lim = $signed({2'b00, cfg_i.integral_limit});
    if (a_sum > a_lim) begin
      a_esum = 17'(a_lim);
    end else if (a_sum < -a_lim) begin
      a_esum = 17'(-a_lim);
    end else begin
      a_esum = 17'(a_sum);
    end
    a_diff = 18'(a_err) - 18'(prev_err_q[a_idx]);

    a_res        = '0;
    a_res.status = q_item_i.status;
    a_res.motor  = q_item_i.motor;
    if (q_item_i.op == OP_FEEDBACK) begin
      a_res.ticks   = a_ticks;
      a_res.rpm     = q_item_i.rpm;
      a_res.current = q_item_i.current;
      a_res.temp    = q_item_i.temp;
    end
  end

  // Final stage: divide by 256 toward zero, clamp, and pack the frame.
  always_comb begin
    f_idx      = MIDX_W'(s3_res_q.motor - 3'd1);
    f_drive_wr = s3_valid_q && (s3_op_q == OP_SETPOINT || s3_op_q == OP_DISABLE);
    f_acc_adj  = s3_acc_q + (s3_acc_q[35] ? 36'sd255 : 36'sd0);
    f_quo      = f_acc_adj[35:8];
    f_lim      = $signed({13'd0, cfg_i.output_limit});
    if (s3_op_q == OP_DISABLE) begin
      f_drive = 16'sd0;
    end else if (f_quo > f_lim) begin
      f_drive = 16'(f_lim);
    end else if (f_quo < -f_lim) begin
      f_drive = 16'(-f_lim);
    end else begin
      f_drive = 16'(f_quo);
    end
  end

  // Drive currents as they stand after this word, one view per motor.
  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_view
    assign drive_view[m] = (f_drive_wr && f_idx == MIDX_W'(m)) ? f_drive : drive_q[m];
  end

  // Slots past the motor count stay zero.
  for (genvar s = 0; s < FRAME_SLOTS; s++) begin : g_slot
    if (s < MOTOR_COUNT) begin : g_used
      assign f_frame[63 - 16*s -: 16] = drive_view[s];
    end else begin : g_unused
      assign f_frame[63 - 16*s -: 16] = 16'd0;
    end
  end

  // Control state and the per-motor register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        prev_angle_q[m] <= '0;
        seen_q[m]       <= 1'b0;
        ticks_q[m]      <= '0;
        rpm_q[m]        <= '0;
        esum_q[m]       <= '0;
        prev_err_q[m]   <= '0;
        drive_q[m]      <= '0;
      end
    end else begin
      if (adv) begin
        s1_valid_q  <= pop;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
      if (pop && q_item_i.op == OP_FEEDBACK) begin
        prev_angle_q[a_idx] <= a_ang;
        seen_q[a_idx]       <= 1'b1;
        ticks_q[a_idx]      <= a_ticks;
        rpm_q[a_idx]        <= q_item_i.rpm;
      end
      if (pop && q_item_i.op == OP_SETPOINT) begin
        esum_q[a_idx]     <= a_esum;
        prev_err_q[a_idx] <= a_err;
      end
      if (adv && f_drive_wr) begin
        drive_q[f_idx] <= f_drive;
      end
    end
  end

  // Pipeline payload: products, their sum, and the output word.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q   <= q_item_i.op;
      s1_res_q  <= a_res;
      s1_err_q  <= a_err;
      s1_esum_q <= a_esum;
      s1_diff_q <= a_diff;

      s2_op_q  <= s1_op_q;
      s2_res_q <= s1_res_q;
      s2_p_q   <= 33'(cfg_i.gain_p) * 33'(s1_err_q);
      s2_i_q   <= 33'(cfg_i.gain_i) * 33'(s1_esum_q);
      s2_d_q   <= 34'(cfg_i.gain_d) * 34'(s1_diff_q);

      s3_op_q  <= s2_op_q;
      s3_res_q <= s2_res_q;
      s3_acc_q <= 36'(s2_p_q) + 36'(s2_i_q) + 36'(s2_d_q);

      out_res_q         <= s3_res_q;
      out_frame_valid_q <= f_drive_wr;
      out_frame_q       <= f_drive_wr ? f_frame : 64'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_res_q.status;
  assign motor_o           = out_res_q.motor;
  assign total_ticks_o     = out_res_q.ticks;
  assign speed_rpm_o       = out_res_q.rpm;
  assign current_raw_o     = out_res_q.current;
  assign temperature_o     = out_res_q.temp;
  assign frame_valid_o     = out_frame_valid_q;
  assign command_payload_o = out_frame_q;

endmodule

FILE: rtl/motor_feedback_and_speed_pid_top.sv
// Top level of the motor feedback and speed PID block: configuration registers,
// front end, queue and execution pipeline. Depends on mfsp_pkg and all mfsp_ modules.
//
// Four-motor bus controller. A feedback word (frame id 0x201 upward) updates that
// motor's rpm and unwrapped encoder total and returns what it unpacked; a setpoint
// word runs the shared-gain speed PID for one motor and returns the packed
// four-current command frame; a disable word zeroes that motor's current and
// returns the frame. The block takes one word per clock while its queue has room
// and delivers one result per clock while the output is ready. Each word passes
// through the execution pipeline: a read-modify-write of the motor's register
// file, a multiply stage, a sum stage and a clamp-and-pack stage into the output
// register, behind a two-word queue. Words of the unused kind are accepted and
// give no result.
// Configuration may be written only while no word is in flight.
module motor_feedback_and_speed_pid_top import mfsp_pkg::*; #(
  parameter int unsigned MOTOR_COUNT    = MOTOR_COUNT_DEF,
  parameter int unsigned ENCODER_COUNTS = ENCODER_COUNTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [10:0]        frame_id_i,
  input  logic [63:0]        payload_i,
  input  logic [2:0]         motor_id_i,
  input  logic signed [15:0] target_rpm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [2:0]         motor_o,
  output logic signed [31:0] total_ticks_o,
  output logic signed [15:0] speed_rpm_o,
  output logic signed [15:0] current_raw_o,
  output logic [7:0]         temperature_o,
  output logic               frame_valid_o,
  output logic [63:0]        command_payload_o
);

  cfg_t        cfg_q;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  front_item_t front_item;
  front_item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= GAIN_P_RST;
      cfg_q.gain_i         <= GAIN_I_RST;
      cfg_q.gain_d         <= GAIN_D_RST;
      cfg_q.integral_limit <= INTEGRAL_LIMIT_RST;
      cfg_q.output_limit   <= OUTPUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_P:         cfg_q.gain_p         <= cfg_wdata_i;
        CFG_GAIN_I:         cfg_q.gain_i         <= cfg_wdata_i;
        CFG_GAIN_D:         cfg_q.gain_d         <= cfg_wdata_i;
        CFG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_wdata_i;
        CFG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_wdata_i[14:0];
        default: begin
        end
      endcase
    end
  end

  // Classifier.
  mfsp_front #(
    .MOTOR_COUNT    (MOTOR_COUNT),
    .ENCODER_COUNTS (ENCODER_COUNTS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .frame_id_i   (frame_id_i),
    .payload_i    (payload_i),
    .motor_id_i   (motor_id_i),
    .target_rpm_i (target_rpm_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .item_o       (front_item)
  );

  // Queue between classifier and execution.
  mfsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Execution pipeline and output register.
  mfsp_back #(
    .MOTOR_COUNT    (MOTOR_COUNT),
    .ENCODER_COUNTS (ENCODER_COUNTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .motor_o           (motor_o),
    .total_ticks_o     (total_ticks_o),
    .speed_rpm_o       (speed_rpm_o),
    .current_raw_o     (current_raw_o),
    .temperature_o     (temperature_o),
    .frame_valid_o     (frame_valid_o),
    .command_payload_o (command_payload_o)
  );

  // A command frame only goes out with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |-> (status_o == STATUS_OK))
    else $error("command frame with a failing status");

  // A rejected word names no motor and carries no frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |->
      (motor_o == 3'd0 && command_payload_o == 64'd0 && total_ticks_o == 32'sd0))
    else $error("rejected word carries data");

  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue overflow");

  // Results never name a motor beyond the motor count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_o <= 3'(MOTOR_COUNT)))
    else $error("result names a motor out of range");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for motor_feedback_and_speed_pid_top: feedback, setpoint
// and disable words against a cycle-free predictor. Depends on mfsp_pkg and the RTL.
module tb_top;
  import mfsp_pkg::*;

  // The unused kind code is accepted by the block but never answered.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int ENC          = ENCODER_COUNTS_DEF;
  localparam int HALF_TURN    = ENC / 2;
  localparam int SETTLE_WAIT  = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_WORDS  = 117;

  typedef struct packed {
    logic [1:0]         kind;
    logic [10:0]        fid;
    logic [63:0]        payload;
    logic [2:0]         mid;
    logic signed [15:0] target;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  motor;
    logic [31:0] ticks;
    logic [15:0] rpm;
    logic [15:0] current;
    logic [7:0]  temp;
    logic        frame_valid;
    logic [63:0] frame;
  } result_t;

  // Block ports.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i = '0;
  logic [10:0]        frame_id_i = '0;
  logic [63:0]        payload_i = '0;
  logic [2:0]         motor_id_i = '0;
  logic signed [15:0] target_rpm_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [2:0]         motor_o;
  logic signed [31:0] total_ticks_o;
  logic signed [15:0] speed_rpm_o;
  logic signed [15:0] current_raw_o;
  logic [7:0]         temperature_o;
  logic               frame_valid_o;
  logic [63:0]        command_payload_o;

  // Shadow copy of the configuration registers.
  logic signed [15:0] gain_p = GAIN_P_RST;
  logic signed [15:0] gain_i = GAIN_I_RST;
  logic signed [15:0] gain_d = GAIN_D_RST;
  logic [15:0]        int_limit = INTEGRAL_LIMIT_RST;
  logic [14:0]        out_limit = OUTPUT_LIMIT_RST;

  // Per-motor state of the predictor.
  logic [12:0]        prev_angle [4] = '{default: '0};
  logic               angle_seen [4] = '{default: 1'b0};
  logic [31:0]        tick_total [4] = '{default: '0};
  logic signed [15:0] rpm_seen [4] = '{default: '0};
  logic signed [16:0] err_sum [4] = '{default: '0};
  logic signed [17:0] prev_err [4] = '{default: '0};
  logic signed [15:0] drive_cur [4] = '{default: '0};

  word_t       word_queue [$];
  result_t     awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 77;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  word_t       accepted_word;
  word_t       next_word;
  result_t     predicted;
  result_t     oldest;
  int unsigned hold_left = 0;
  bit          hold_taken = 1'b0;

  motor_feedback_and_speed_pid_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Works out what one word does to the motor state and what it returns.
  function automatic bit control_step(input word_t w, output result_t r);
    int     m;
    int     angle;
    int     step;
    longint err;
    longint sum;
    longint acc;
    longint lim;
    r = '0;
    if (w.kind == KIND_UNUSED) return 1'b0;
    if (w.kind == KIND_FEEDBACK) begin
      if (w.fid <= FEEDBACK_BASE || w.fid > FEEDBACK_BASE + 11'(MOTOR_COUNT_DEF)) begin
        r.status = STATUS_BAD_FRAME;
        return 1'b1;
      end
      m = int'(w.fid - FEEDBACK_BASE) - 1;
      angle = int'(w.payload[63:48]) % ENC;
      rpm_seen[m] = w.payload[47:32];
      // The first angle of a motor serves as its own previous angle.
      if (!angle_seen[m]) begin
        prev_angle[m] = 13'(angle);
        angle_seen[m] = 1'b1;
      end
      step = angle - int'(prev_angle[m]);
      if (step > HALF_TURN) begin
        step -= ENC;
      end else if (step < -HALF_TURN) begin
        step += ENC;
      end
      tick_total[m] = tick_total[m] + 32'(step);
      prev_angle[m] = 13'(angle);
      r.status = STATUS_OK;
      r.motor = 3'(m + 1);
      r.ticks = tick_total[m];
      r.rpm = rpm_seen[m];
      r.current = w.payload[31:16];
      r.temp = w.payload[15:8];
      return 1'b1;
    end
    if (w.mid == 3'd0 || w.mid > MOTOR_COUNT_DEF) begin
      r.status = STATUS_BAD_MOTOR;
      return 1'b1;
    end
    m = int'(w.mid) - 1;
    if (w.kind == KIND_SETPOINT) begin
      // Speed PID with clamped integral, Q8.8 gains and truncation toward zero.
      err = longint'(w.target) - longint'(rpm_seen[m]);
      lim = longint'(int_limit);
      sum = longint'(err_sum[m]) + err;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      err_sum[m] = 17'(sum);
      acc = longint'(gain_p) * err + longint'(gain_i) * sum
          + longint'(gain_d) * (err - longint'(prev_err[m]));
      acc = acc / 256;
      lim = longint'(out_limit);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      drive_cur[m] = 16'(acc);
      prev_err[m] = 18'(err);
    end else begin
      drive_cur[m] = '0;
    end
    r.status = STATUS_OK;
    r.motor = w.mid;
    r.frame_valid = 1'b1;
    r.frame = {drive_cur[0], drive_cur[1], drive_cur[2], drive_cur[3]};
    return 1'b1;
  endfunction

  function automatic word_t make_word(input logic [1:0] kind, input logic [10:0] fid,
                                      input logic [63:0] payload, input logic [2:0] mid,
                                      input logic [15:0] target);
    word_t w;
    w.kind = kind;
    w.fid = fid;
    w.payload = payload;
    w.mid = mid;
    w.target = target;
    return w;
  endfunction

  // Mostly valid ids and in-range angles, with small speeds half of the time.
  function automatic word_t random_word();
    word_t       w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      w.kind = KIND_FEEDBACK;
    end else if (pick < 80) begin
      w.kind = KIND_SETPOINT;
    end else if (pick < 96) begin
      w.kind = KIND_DISABLE;
    end else begin
      w.kind = KIND_UNUSED;
    end
    if ($urandom_range(9) == 0) begin
      w.fid = 11'($urandom);
    end else begin
      w.fid = FEEDBACK_BASE + 11'($urandom_range(MOTOR_COUNT_DEF, 1));
    end
    w.payload = {$urandom, $urandom};
    if ($urandom_range(99) < 70) w.payload[63:48] = 16'($urandom_range(ENC - 1));
    if ($urandom_range(1) == 1) w.payload[47:32] = 16'($urandom_range(4000) - 2000);
    if ($urandom_range(9) == 0) begin
      w.mid = 3'($urandom);
    end else begin
      w.mid = 3'($urandom_range(MOTOR_COUNT_DEF, 1));
    end
    if ($urandom_range(1) == 1) begin
      w.target = 16'($urandom);
    end else begin
      w.target = 16'($urandom_range(4000) - 2000);
    end
    return w;
  endfunction

  task automatic note_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_GAIN_P:         gain_p = data;
      CFG_GAIN_I:         gain_i = data;
      CFG_GAIN_D:         gain_d = data;
      CFG_INTEGRAL_LIMIT: int_limit = data;
      CFG_OUTPUT_LIMIT:   out_limit = data[14:0];
      default:            ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] gp, input logic [15:0] gi,
                            input logic [15:0] gd, input logic [15:0] il,
                            input logic [15:0] ol);
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_INTEGRAL_LIMIT, il);
    write_reg(CFG_OUTPUT_LIMIT, ol);
  endtask

  // Waits until every word is sent and answered, then lets unanswered words drain.
  task automatic settle();
    do @(negedge clk_i);
    while (word_queue.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Driver: predicts each accepted word and offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        accepted_word.kind = kind_i;
        accepted_word.fid = frame_id_i;
        accepted_word.payload = payload_i;
        accepted_word.mid = motor_id_i;
        accepted_word.target = target_rpm_i;
        if (control_step(accepted_word, predicted)) awaited_results.push_back(predicted);
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_queue.pop_front();
          in_valid_i <= 1'b1;
          kind_i <= next_word.kind;
          frame_id_i <= next_word.fid;
          payload_i <= next_word.payload;
          motor_id_i <= next_word.mid;
          target_rpm_i <= next_word.target;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result arrived with nothing awaited");
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", status_o, oldest.status);
          check_field("motor", motor_o, oldest.motor);
          check_field("total_ticks", $unsigned(total_ticks_o), oldest.ticks);
          check_field("speed_rpm", $unsigned(speed_rpm_o), oldest.rpm);
          check_field("current_raw", $unsigned(current_raw_o), oldest.current);
          check_field("temperature", temperature_o, oldest.temp);
          check_field("frame_valid", frame_valid_o, oldest.frame_valid);
          check_field("command_payload", command_payload_o, oldest.frame);
        end
      end
      // One long hold-off lets the block fill up and push back on its input.
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Counts cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("FAIL motor_feedback_and_speed_pid_top");
    $finish;
  end

  // Stimulus: directed words, then random phases under changing settings.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_config(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, INTEGRAL_LIMIT_RST,
               {1'b0, OUTPUT_LIMIT_RST});

    // Unwrap across both seam directions, an exact half turn, and raw angles
    // beyond one turn.
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h201,
                                   {16'd100, 16'h7fff, 16'h8000, 8'hff, 8'haa}, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h201,
                                   {16'd8000, 16'h0000, 16'h0001, 8'h10, 8'h00}, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h201,
                                   {16'd50, 16'h0010, 16'h0000, 8'h20, 8'h00}, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h201,
                                   {16'hffff, 16'h8000, 16'h7fff, 8'h00, 8'hff}, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h202, 64'd0, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h202, {16'd4096, 48'd0}, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h202, 64'd0, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h203, '1, 3'd7, 16'hffff));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h204, 64'd0, 3'd0, 16'd0));
    // Frame ids outside the motor range.
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h200, '1, 3'd1, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h205, '1, 3'd1, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h7ff, 64'd0, 3'd1, 16'd0));
    word_queue.push_back(make_word(KIND_FEEDBACK, 11'h000, 64'd0, 3'd1, 16'd0));
    // Setpoints on every motor, most of them at the speed extremes.
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h000, 64'd0, 3'd1, 16'h7fff));
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h000, 64'd0, 3'd1, 16'h8000));
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h000, 64'd0, 3'd2, 16'd0));
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h000, 64'd0, 3'd3, 16'h7fff));
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h7ff, '1, 3'd4, 16'h8000));
    // Motor numbers outside the valid range, mixed with a valid disable, a valid setpoint and an unused-kind word.
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h201, 64'd0, 3'd0, 16'd100));
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h201, 64'd0, 3'd5, 16'd100));
    word_queue.push_back(make_word(KIND_DISABLE, 11'h201, 64'd0, 3'd7, 16'd0));
    word_queue.push_back(make_word(KIND_DISABLE, 11'h201, 64'd0, 3'd2, 16'd0));
    word_queue.push_back(make_word(KIND_DISABLE, 11'h201, 64'd0, 3'd0, 16'd0));
    word_queue.push_back(make_word(KIND_UNUSED, 11'h201, '1, 3'd1, 16'h7fff));
    word_queue.push_back(make_word(KIND_SETPOINT, 11'h000, 64'd0, 3'd2, 16'd100));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(16'd256, 16'd64, 16'd128, 16'hffff, 16'h7fff);
        1: set_config(16'h8000, 16'h7fff, 16'h8000, 16'd0, 16'd0);
        2: set_config(16'h7fff, 16'h8000, 16'h7fff, 16'd1, 16'hffff);
        5: set_config(16'd512, -16'sd300, -16'sd64, 16'd2000, 16'd300);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom));
      endcase
      send_idle_pct <= (ph < 2) ? 33 : (ph < 4) ? 77 : 0;
      recv_idle_pct <= (ph < 2) ? 77 : (ph < 4) ? 33 : 0;
      for (int k = 0; k < PHASE_WORDS; k++) word_queue.push_back(random_word());
      if (ph == 4) hold_request <= 1'b1;
      settle();
    end

    if (mismatch_count == 0) begin
      $display("PASS motor_feedback_and_speed_pid_top");
    end else begin
      $display("FAIL motor_feedback_and_speed_pid_top");
    end
    $finish;
  end

endmodule
